// File: rtl/core/lkah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkah_pkg
// Shared widths, types and codes for the segment lookahead pipeline.
// ----------------------------------------------------------------------------
package lkah_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // coordinate difference
    localparam int PW    = 2 * DW;          // product of two differences
    localparam int VVW   = PW;              // squared segment length
    localparam int DOTW  = PW + 1;          // projection dot product
    localparam int AW    = PW;              // magnitude of a cross component
    localparam int AL    = AW / 2;
    localparam int AH    = AW - AL;
    localparam int SQW   = 2 * AW;          // square of a cross component
    localparam int CCW   = SQW + 2;         // sum of three squares
    localparam int LW    = CW - 1;          // positive lookahead magnitude
    localparam int L2W   = 2 * LW;
    localparam int L2L   = L2W / 2;
    localparam int L2H   = L2W - L2L;
    localparam int VVL   = VVW / 2;
    localparam int VVH   = VVW - VVL;
    localparam int RADW  = L2W + VVW;       // radicand
    localparam int ROOTW = RADW / 2;
    localparam int NW    = DOTW + 1;        // advanced numerator
    localparam int QW    = FRAC_BITS;       // quotient bits
    localparam int TW    = FRAC_BITS + 1;   // seg_param width
    localparam int MW    = QW + 1 + DW;     // quotient times difference

    localparam int GEOM_STAGES   = 6;
    localparam int DIV_STAGES    = 1 + QW;
    localparam int INTERP_STAGES = 2;
    localparam int LATENCY = GEOM_STAGES + ROOTW + DIV_STAGES + INTERP_STAGES;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_MID   = 2'd2
    } mode_t;

    typedef struct packed {
        logic                  bad;
        logic [2:0][CW-1:0]    s;
        logic [2:0][DW-1:0]    v;
    } base_t;

    typedef struct packed {
        base_t                 base;
        logic [DOTW-1:0]       dot;
        logic [VVW-1:0]        vv;
    } side_t;

endpackage

// File: rtl/core/lkah_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkah_geom
// Six-stage front end: differences, products, dot and cross terms, and the
// radicand L^2*|v|^2 - |v x w|^2 clipped at zero.
// ----------------------------------------------------------------------------
module lkah_geom
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [2:0][lkah_pkg::CW-1:0]       c,
    input  logic [2:0][lkah_pkg::CW-1:0]       s,
    input  logic [2:0][lkah_pkg::CW-1:0]       e,
    input  logic [lkah_pkg::CW-1:0]            look,
    output logic                               out_valid,
    output logic [lkah_pkg::RADW-1:0]          radicand,
    output lkah_pkg::side_t                    side
);

    localparam int CW = lkah_pkg::CW;
    localparam int DW = lkah_pkg::DW;
    localparam int PW = lkah_pkg::PW;

    logic [5:0]              vld_reg;
    lkah_pkg::base_t         base_reg [6];
    lkah_pkg::base_t         base_next;
    logic [2:0][DW-1:0]      w1_reg;
    logic [lkah_pkg::LW-1:0] l1_reg;
    logic                    look_bad;

    // Stage 1: a bad lookahead is folded into a zero-length segment at C.
    assign look_bad = look[CW-1] || (look == '0);

    always_comb
    begin
        base_next.bad = look_bad;
        for (int k = 0; k < 3; k++)
        begin
            base_next.s[k] = look_bad ? c[k] : s[k];
            base_next.v[k] = look_bad ? '0
                           : DW'($signed({e[k][CW-1], e[k]}) - $signed({s[k][CW-1], s[k]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg[0] <= base_next;
        for (int k = 0; k < 3; k++)
        begin
            w1_reg[k] <= DW'($signed({c[k][CW-1], c[k]}) - $signed({s[k][CW-1], s[k]}));
        end
        l1_reg <= look_bad ? '0 : look[lkah_pkg::LW-1:0];
        for (int i = 1; i < 6; i++)
        begin
            base_reg[i] <= base_reg[i-1];
        end
    end

    // Stage 2: single products.
    logic signed [PW-1:0]       pvv_reg [3];
    logic signed [PW-1:0]       pdot_reg [3];
    logic signed [PW-1:0]       px1_reg [3];
    logic signed [PW-1:0]       px2_reg [3];
    logic [lkah_pkg::L2W-1:0]   l2_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_prod
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        always_ff @(posedge clk)
        begin
            pvv_reg[k]  <= $signed(base_reg[0].v[k]) * $signed(base_reg[0].v[k]);
            pdot_reg[k] <= $signed(base_reg[0].v[k]) * $signed(w1_reg[k]);
            px1_reg[k]  <= $signed(base_reg[0].v[K1]) * $signed(w1_reg[K2]);
            px2_reg[k]  <= $signed(base_reg[0].v[K2]) * $signed(w1_reg[K1]);
        end
    end

    always_ff @(posedge clk)
    begin
        l2_reg <= lkah_pkg::L2W'(l1_reg) * lkah_pkg::L2W'(l1_reg);
    end

    // Stage 3: sums and cross magnitudes.
    logic [lkah_pkg::VVW-1:0]   vv3_reg, vv4_reg, vv5_reg, vv6_reg;
    logic [lkah_pkg::DOTW-1:0]  dot3_reg, dot4_reg, dot5_reg, dot6_reg;
    logic [lkah_pkg::AW-1:0]    ax_reg [3];
    logic [lkah_pkg::L2W-1:0]   l2b_reg;
    logic signed [lkah_pkg::DOTW-1:0] cross_term [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_cross
        assign cross_term[k] = lkah_pkg::DOTW'(px1_reg[k]) - lkah_pkg::DOTW'(px2_reg[k]);
        always_ff @(posedge clk)
        begin
            ax_reg[k] <= cross_term[k][lkah_pkg::DOTW-1]
                       ? lkah_pkg::AW'(-cross_term[k]) : lkah_pkg::AW'(cross_term[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        vv3_reg  <= lkah_pkg::VVW'(pvv_reg[0]) + lkah_pkg::VVW'(pvv_reg[1])
                  + lkah_pkg::VVW'(pvv_reg[2]);
        dot3_reg <= lkah_pkg::DOTW'(pdot_reg[0]) + lkah_pkg::DOTW'(pdot_reg[1])
                  + lkah_pkg::DOTW'(pdot_reg[2]);
        l2b_reg  <= l2_reg;
        vv4_reg  <= vv3_reg;
        vv5_reg  <= vv4_reg;
        vv6_reg  <= vv5_reg;
        dot4_reg <= dot3_reg;
        dot5_reg <= dot4_reg;
        dot6_reg <= dot5_reg;
    end

    // Stage 4: partial products of the wide squares.
    logic [2*lkah_pkg::AH-1:0]              hh_reg [3];
    logic [lkah_pkg::AH+lkah_pkg::AL-1:0]   hl_reg [3];
    logic [2*lkah_pkg::AL-1:0]              ll_reg [3];
    logic [lkah_pkg::L2H+lkah_pkg::VVH-1:0] lhvh_reg;
    logic [lkah_pkg::L2H+lkah_pkg::VVL-1:0] lhvl_reg;
    logic [lkah_pkg::L2L+lkah_pkg::VVH-1:0] llvh_reg;
    logic [lkah_pkg::L2L+lkah_pkg::VVL-1:0] llvl_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_part
        always_ff @(posedge clk)
        begin
            hh_reg[k] <= (2*lkah_pkg::AH)'(ax_reg[k][lkah_pkg::AW-1:lkah_pkg::AL])
                       * (2*lkah_pkg::AH)'(ax_reg[k][lkah_pkg::AW-1:lkah_pkg::AL]);
            hl_reg[k] <= (lkah_pkg::AH+lkah_pkg::AL)'(ax_reg[k][lkah_pkg::AW-1:lkah_pkg::AL])
                       * (lkah_pkg::AH+lkah_pkg::AL)'(ax_reg[k][lkah_pkg::AL-1:0]);
            ll_reg[k] <= (2*lkah_pkg::AL)'(ax_reg[k][lkah_pkg::AL-1:0])
                       * (2*lkah_pkg::AL)'(ax_reg[k][lkah_pkg::AL-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        lhvh_reg <= (lkah_pkg::L2H+lkah_pkg::VVH)'(l2b_reg[lkah_pkg::L2W-1:lkah_pkg::L2L])
                  * (lkah_pkg::L2H+lkah_pkg::VVH)'(vv3_reg[lkah_pkg::VVW-1:lkah_pkg::VVL]);
        lhvl_reg <= (lkah_pkg::L2H+lkah_pkg::VVL)'(l2b_reg[lkah_pkg::L2W-1:lkah_pkg::L2L])
                  * (lkah_pkg::L2H+lkah_pkg::VVL)'(vv3_reg[lkah_pkg::VVL-1:0]);
        llvh_reg <= (lkah_pkg::L2L+lkah_pkg::VVH)'(l2b_reg[lkah_pkg::L2L-1:0])
                  * (lkah_pkg::L2L+lkah_pkg::VVH)'(vv3_reg[lkah_pkg::VVW-1:lkah_pkg::VVL]);
        llvl_reg <= (lkah_pkg::L2L+lkah_pkg::VVL)'(l2b_reg[lkah_pkg::L2L-1:0])
                  * (lkah_pkg::L2L+lkah_pkg::VVL)'(vv3_reg[lkah_pkg::VVL-1:0]);
    end

    // Stage 5: assemble the squares and L^2*vv.
    logic [lkah_pkg::SQW-1:0]  sq_reg [3];
    logic [lkah_pkg::RADW-1:0] l2vv_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_sq
        always_ff @(posedge clk)
        begin
            sq_reg[k] <= (lkah_pkg::SQW'(hh_reg[k]) << (2*lkah_pkg::AL))
                       + (lkah_pkg::SQW'(hl_reg[k]) << (lkah_pkg::AL+1))
                       + lkah_pkg::SQW'(ll_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        l2vv_reg <= (lkah_pkg::RADW'(lhvh_reg) << (lkah_pkg::L2L+lkah_pkg::VVL))
                  + (lkah_pkg::RADW'(lhvl_reg) << lkah_pkg::L2L)
                  + (lkah_pkg::RADW'(llvh_reg) << lkah_pkg::VVL)
                  + lkah_pkg::RADW'(llvl_reg);
    end

    // Stage 6: radicand, zero unless strictly positive.
    logic [lkah_pkg::CCW:0]    rad_full;
    logic [lkah_pkg::RADW-1:0] rad_reg;

    assign rad_full = (lkah_pkg::CCW+1)'(l2vv_reg)
                    - ((lkah_pkg::CCW+1)'(sq_reg[0]) + (lkah_pkg::CCW+1)'(sq_reg[1])
                     + (lkah_pkg::CCW+1)'(sq_reg[2]));

    always_ff @(posedge clk)
    begin
        rad_reg <= (!rad_full[lkah_pkg::CCW] && (rad_full != '0))
                 ? rad_full[lkah_pkg::RADW-1:0] : '0;
    end

    assign out_valid = vld_reg[5];
    assign radicand  = rad_reg;
    assign side.base = base_reg[5];
    assign side.dot  = dot6_reg;
    assign side.vv   = vv6_reg;

endmodule

// File: rtl/core/lkah_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkah_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lkah_isqrt
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [lkah_pkg::RADW-1:0]       radicand,
    input  lkah_pkg::side_t                 in_side,
    output logic                            out_valid,
    output logic [lkah_pkg::ROOTW-1:0]      root,
    output lkah_pkg::side_t                 out_side
);

    localparam int ROOTW = lkah_pkg::ROOTW;
    localparam int RW    = lkah_pkg::RADW + 1;

    logic                  stg_vld  [ROOTW+1];
    logic [RW-1:0]         stg_rem  [ROOTW+1];
    logic [ROOTW-1:0]      stg_root [ROOTW+1];
    lkah_pkg::side_t       stg_side [ROOTW+1];

    assign stg_vld[0]  = in_valid;
    assign stg_rem[0]  = RW'(radicand);
    assign stg_root[0] = '0;
    assign stg_side[0] = in_side;

    for (genvar i = 0; i < ROOTW; i++)
    begin : g_stage
        localparam int B = ROOTW - 1 - i;
        logic             vld_reg;
        logic [RW-1:0]    rem_reg;
        logic [ROOTW-1:0] root_reg;
        lkah_pkg::side_t  side_reg;
        logic [RW-1:0]    trial;
        logic             take;

        // Remainder holds radicand minus root squared for the bits decided so far.
        assign trial = (RW'(stg_root[i]) << (B + 1)) + (RW'(1) << (2 * B));
        assign take  = stg_rem[i] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= stg_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= take ? (stg_rem[i] - trial) : stg_rem[i];
            root_reg <= take ? (stg_root[i] | (ROOTW'(1) << B)) : stg_root[i];
            side_reg <= stg_side[i];
        end

        assign stg_vld[i+1]  = vld_reg;
        assign stg_rem[i+1]  = rem_reg;
        assign stg_root[i+1] = root_reg;
        assign stg_side[i+1] = side_reg;
    end

    assign out_valid = stg_vld[ROOTW];
    assign root      = stg_root[ROOTW];
    assign out_side  = stg_side[ROOTW];

endmodule

// File: rtl/core/lkah_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkah_div
// Advances the projection by the root, classifies the parameter and divides
// the numerator by the squared length, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lkah_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [lkah_pkg::ROOTW-1:0]    root,
    input  lkah_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [lkah_pkg::QW-1:0]       quot,
    output lkah_pkg::mode_t               mode,
    output lkah_pkg::base_t               base
);

    localparam int QW  = lkah_pkg::QW;
    localparam int VVW = lkah_pkg::VVW;
    localparam int NW  = lkah_pkg::NW;

    logic signed [NW-1:0] num;
    logic                 nonpos;
    logic                 reach;
    lkah_pkg::mode_t      mode_next;

    assign num = $signed({{(NW-lkah_pkg::DOTW){in_side.dot[lkah_pkg::DOTW-1]}}, in_side.dot})
               + $signed({{(NW-lkah_pkg::ROOTW){1'b0}}, root});
    assign nonpos = num[NW-1] || (num == '0);
    assign reach  = num[NW-2:0] >= (NW-1)'(in_side.vv);

    always_comb
    begin
        if (nonpos)
        begin
            mode_next = lkah_pkg::MODE_START;
        end
        else if (reach)
        begin
            mode_next = lkah_pkg::MODE_END;
        end
        else
        begin
            mode_next = lkah_pkg::MODE_MID;
        end
    end

    logic              stg_vld  [QW+1];
    logic [VVW-1:0]    stg_rem  [QW+1];
    logic [QW-1:0]     stg_q    [QW+1];
    lkah_pkg::mode_t   stg_mode [QW+1];
    lkah_pkg::side_t   stg_side [QW+1];

    logic              vld0_reg;
    logic [VVW-1:0]    rem0_reg;
    lkah_pkg::mode_t   mode0_reg;
    lkah_pkg::side_t   side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg  <= num[VVW-1:0];
        mode0_reg <= mode_next;
        side0_reg <= in_side;
    end

    assign stg_vld[0]  = vld0_reg;
    assign stg_rem[0]  = rem0_reg;
    assign stg_q[0]    = '0;
    assign stg_mode[0] = mode0_reg;
    assign stg_side[0] = side0_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic             vld_reg;
        logic [VVW-1:0]   rem_reg;
        logic [QW-1:0]    q_reg;
        lkah_pkg::mode_t  mode_reg;
        lkah_pkg::side_t  side_reg;
        logic [VVW:0]     dbl;
        logic             take;

        assign dbl  = {stg_rem[i], 1'b0};
        assign take = dbl >= {1'b0, stg_side[i].vv};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= stg_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= take ? VVW'(dbl - {1'b0, stg_side[i].vv}) : dbl[VVW-1:0];
            q_reg    <= {stg_q[i][QW-2:0], take};
            mode_reg <= stg_mode[i];
            side_reg <= stg_side[i];
        end

        assign stg_vld[i+1]  = vld_reg;
        assign stg_rem[i+1]  = rem_reg;
        assign stg_q[i+1]    = q_reg;
        assign stg_mode[i+1] = mode_reg;
        assign stg_side[i+1] = side_reg;
    end

    assign out_valid = stg_vld[QW];
    assign quot      = stg_q[QW];
    assign mode      = stg_mode[QW];
    assign base      = stg_side[QW].base;

endmodule

// File: rtl/core/lkah_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkah_interp
// Scales the segment by the parameter, rounds, and registers the result.
// ----------------------------------------------------------------------------
module lkah_interp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [lkah_pkg::QW-1:0]     quot,
    input  lkah_pkg::mode_t             mode,
    input  lkah_pkg::base_t             base,
    output logic                        out_valid,
    output logic [2:0][lkah_pkg::CW-1:0] point,
    output logic [lkah_pkg::TW-1:0]     param,
    output logic                        bad
);

    localparam int CW = lkah_pkg::CW;
    localparam int MW = lkah_pkg::MW;
    localparam int F  = lkah_pkg::FRAC_BITS;

    logic                    vld_a_reg;
    logic signed [MW-1:0]    prod_reg [3];
    logic [lkah_pkg::QW-1:0] q_a_reg;
    lkah_pkg::mode_t         mode_a_reg;
    lkah_pkg::base_t         base_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
            out_valid <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_reg[k] <= $signed({1'b0, quot}) * $signed(base.v[k]);
        end
        q_a_reg    <= quot;
        mode_a_reg <= mode;
        base_a_reg <= base;
    end

    logic [2:0][CW-1:0]      point_next;
    logic [lkah_pkg::TW-1:0] param_next;
    logic signed [MW-1:0]    rnd [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_rnd
        assign rnd[k] = (prod_reg[k] + MW'(1 << (F - 1))) >>> F;
    end

    always_comb
    begin
        unique case (mode_a_reg)
            lkah_pkg::MODE_END:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    point_next[k] = base_a_reg.s[k] + base_a_reg.v[k][CW-1:0];
                end
                param_next = lkah_pkg::TW'(1) << F;
            end
            lkah_pkg::MODE_MID:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    point_next[k] = base_a_reg.s[k] + rnd[k][CW-1:0];
                end
                param_next = {1'b0, q_a_reg};
            end
            default:
            begin
                point_next = base_a_reg.s;
                param_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        point <= point_next;
        param <= param_next;
        bad   <= base_a_reg.bad;
    end

endmodule

// File: rtl/core/pure_pursuit_segment_lookahead.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_segment_lookahead
// Pure pursuit lookahead point on one 3D segment, exact fixed-point pipeline.
// ----------------------------------------------------------------------------
//  Channel  | Handshake       | Payload
//  ---------+-----------------+------------------------------------------------
//  request  | start / busy    | cur_*, start_*, end_*, look_dist (Q15.16)
//  result   | done (strobe)   | next_x/y/z (Q15.16), seg_param, bad_lookahead
//
// A transfer is taken on every cycle in which start is high; busy is always
// low, as the pipeline never stalls. Each result's delay is set chiefly by
// the 64-stage square root and the divider, one quotient bit per stage.
// Reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so results leave in order as done strobes.
// ----------------------------------------------------------------------------
module pure_pursuit_segment_lookahead
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lkah_pkg::CW-1:0]    cur_x,
    input  logic signed [lkah_pkg::CW-1:0]    cur_y,
    input  logic signed [lkah_pkg::CW-1:0]    cur_z,
    input  logic signed [lkah_pkg::CW-1:0]    start_x,
    input  logic signed [lkah_pkg::CW-1:0]    start_y,
    input  logic signed [lkah_pkg::CW-1:0]    start_z,
    input  logic signed [lkah_pkg::CW-1:0]    end_x,
    input  logic signed [lkah_pkg::CW-1:0]    end_y,
    input  logic signed [lkah_pkg::CW-1:0]    end_z,
    input  logic signed [lkah_pkg::CW-1:0]    look_dist,
    output logic                              done,
    output logic signed [lkah_pkg::CW-1:0]    next_x,
    output logic signed [lkah_pkg::CW-1:0]    next_y,
    output logic signed [lkah_pkg::CW-1:0]    next_z,
    output logic [lkah_pkg::TW-1:0]           seg_param,
    output logic                              bad_lookahead
);

    // The pipeline accepts a transfer every cycle.
    assign busy = 1'b0;

    logic [2:0][lkah_pkg::CW-1:0] cur_v, start_v, end_v, point;

    assign cur_v   = {cur_z, cur_y, cur_x};
    assign start_v = {start_z, start_y, start_x};
    assign end_v   = {end_z, end_y, end_x};

    // Geometry front end: produces the radicand and the values that ride along.
    logic                       geom_valid;
    logic [lkah_pkg::RADW-1:0]  geom_rad;
    lkah_pkg::side_t            geom_side;

    lkah_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .c         (cur_v),
        .s         (start_v),
        .e         (end_v),
        .look      (look_dist),
        .out_valid (geom_valid),
        .radicand  (geom_rad),
        .side      (geom_side)
    );

    // Square root of the radicand, one bit per stage.
    logic                        sqrt_valid;
    logic [lkah_pkg::ROOTW-1:0]  sqrt_root;
    lkah_pkg::side_t             sqrt_side;

    lkah_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .radicand  (geom_rad),
        .in_side   (geom_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    // Parameter classification and fractional division.
    logic                     div_valid;
    logic [lkah_pkg::QW-1:0]  div_quot;
    lkah_pkg::mode_t          div_mode;
    lkah_pkg::base_t          div_base;

    lkah_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .mode      (div_mode),
        .base      (div_base)
    );

    // Interpolation along the segment and the output register.
    lkah_interp u_interp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .quot      (div_quot),
        .mode      (div_mode),
        .base      (div_base),
        .out_valid (done),
        .point     (point),
        .param     (seg_param),
        .bad       (bad_lookahead)
    );

    assign next_x = point[0];
    assign next_y = point[1];
    assign next_z = point[2];

    // Every result stems from an earlier transfer, delayed by the full pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lkah_pkg::LATENCY))
        else $error("result without a matching request");

    // A rejected lookahead always reports a zero parameter.
    a_bad_param: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_lookahead) |-> (seg_param == '0))
        else $error("bad lookahead with non-zero parameter");

    // The clamped parameter never exceeds one.
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (seg_param <= (lkah_pkg::TW'(1) << lkah_pkg::FRAC_BITS)))
        else $error("parameter above one");

    // A rejected lookahead returns the current position unchanged (x and z checked).
    a_bad_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_lookahead) |->
            (next_x == $past(cur_x, lkah_pkg::LATENCY))
         && (next_z == $past(cur_z, lkah_pkg::LATENCY)))
        else $error("bad lookahead did not return the current point");

endmodule

// File: dv/pure_pursuit_segment_lookahead_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_segment_lookahead_checker
// Watches the request and result channels, predicts each result and compares.
// ----------------------------------------------------------------------------
module pure_pursuit_segment_lookahead_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [lkah_pkg::CW-1:0]    cur_x,
    input  logic signed [lkah_pkg::CW-1:0]    cur_y,
    input  logic signed [lkah_pkg::CW-1:0]    cur_z,
    input  logic signed [lkah_pkg::CW-1:0]    start_x,
    input  logic signed [lkah_pkg::CW-1:0]    start_y,
    input  logic signed [lkah_pkg::CW-1:0]    start_z,
    input  logic signed [lkah_pkg::CW-1:0]    end_x,
    input  logic signed [lkah_pkg::CW-1:0]    end_y,
    input  logic signed [lkah_pkg::CW-1:0]    end_z,
    input  logic signed [lkah_pkg::CW-1:0]    look_dist,
    input  logic                              done,
    input  logic signed [lkah_pkg::CW-1:0]    next_x,
    input  logic signed [lkah_pkg::CW-1:0]    next_y,
    input  logic signed [lkah_pkg::CW-1:0]    next_z,
    input  logic [lkah_pkg::TW-1:0]           seg_param,
    input  logic                              bad_lookahead,
    output int                                mismatches,
    output int                                outstanding,
    output int                                compared
);

    typedef logic signed [255:0]        wide_t;
    typedef logic [lkah_pkg::CW-1:0]    coord_t;

    typedef struct {
        coord_t                  px;
        coord_t                  py;
        coord_t                  pz;
        logic [lkah_pkg::TW-1:0] param;
        logic                    bad;
    } point_t;

    point_t pending_points[$];

    // Integer square root, floor, by the bit-pair method.
    function automatic wide_t floor_sqrt(input wide_t rad);
        logic [255:0] rem;
        logic [255:0] res;
        logic [255:0] bitv;
        rem  = rad;
        res  = '0;
        bitv = 256'd1 << 254;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return wide_t'(res);
    endfunction

    function automatic point_t lookahead_point(input coord_t c [3], input coord_t s [3],
                                               input coord_t e [3], input coord_t ld);
        point_t p;
        wide_t  v [3];
        wide_t  w [3];
        wide_t  vv, dotp, cross2, cr, rad, num, tt, d, lw;
        int     k, k1, k2;
        vv     = 0;
        dotp   = 0;
        cross2 = 0;
        lw     = wide_t'($signed(ld));
        p.bad  = 1'b0;
        if (lw <= 0)
        begin
            p.px    = c[0];
            p.py    = c[1];
            p.pz    = c[2];
            p.param = '0;
            p.bad   = 1'b1;
            return p;
        end
        for (k = 0; k < 3; k++)
        begin
            v[k] = wide_t'($signed(e[k])) - wide_t'($signed(s[k]));
            w[k] = wide_t'($signed(c[k])) - wide_t'($signed(s[k]));
        end
        for (k = 0; k < 3; k++)
        begin
            k1     = (k + 1) % 3;
            k2     = (k + 2) % 3;
            vv     = vv + v[k] * v[k];
            dotp   = dotp + v[k] * w[k];
            cr     = v[k1] * w[k2] - v[k2] * w[k1];
            cross2 = cross2 + cr * cr;
        end
        if (vv == 0)
        begin
            p.px    = s[0];
            p.py    = s[1];
            p.pz    = s[2];
            p.param = '0;
            return p;
        end
        rad = lw * lw * vv - cross2;
        num = dotp;
        if (rad > 0)
            num = num + floor_sqrt(rad);
        if (num <= 0)
        begin
            p.px    = s[0];
            p.py    = s[1];
            p.pz    = s[2];
            p.param = '0;
        end
        else if (num >= vv)
        begin
            p.px    = e[0];
            p.py    = e[1];
            p.pz    = e[2];
            p.param = lkah_pkg::TW'(1) << lkah_pkg::FRAC_BITS;
        end
        else
        begin
            tt      = (num <<< lkah_pkg::FRAC_BITS) / vv;
            p.param = tt[lkah_pkg::TW-1:0];
            d       = (tt * v[0] + (wide_t'(1) <<< (lkah_pkg::FRAC_BITS - 1)))
                      >>> lkah_pkg::FRAC_BITS;
            p.px    = s[0] + d[lkah_pkg::CW-1:0];
            d       = (tt * v[1] + (wide_t'(1) <<< (lkah_pkg::FRAC_BITS - 1)))
                      >>> lkah_pkg::FRAC_BITS;
            p.py    = s[1] + d[lkah_pkg::CW-1:0];
            d       = (tt * v[2] + (wide_t'(1) <<< (lkah_pkg::FRAC_BITS - 1)))
                      >>> lkah_pkg::FRAC_BITS;
            p.pz    = s[2] + d[lkah_pkg::CW-1:0];
        end
        return p;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
    end

    always @(posedge clk)
    begin
        coord_t c [3];
        coord_t s [3];
        coord_t e [3];
        point_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_points.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %h %h %h %h %b", $time,
                             next_x, next_y, next_z, seg_param, bad_lookahead);
                    mismatches++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    compared++;
                    if (next_x !== want.px || next_y !== want.py || next_z !== want.pz ||
                        seg_param !== want.param || bad_lookahead !== want.bad)
                    begin
                        $display("%0t: expected %h %h %h t=%h bad=%b, got %h %h %h t=%h bad=%b",
                                 $time, want.px, want.py, want.pz, want.param, want.bad,
                                 next_x, next_y, next_z, seg_param, bad_lookahead);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                c = '{cur_x, cur_y, cur_z};
                s = '{start_x, start_y, start_z};
                e = '{end_x, end_y, end_z};
                pending_points.push_back(lookahead_point(c, s, e, look_dist));
            end
            outstanding = pending_points.size();
        end
    end

endmodule

// File: dv/pure_pursuit_segment_lookahead_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_segment_lookahead_test
// Drives lookahead requests with random gaps; a checker predicts the results.
// ----------------------------------------------------------------------------
// A short directed set covers a non-positive lookahead, a zero-length
// segment, coordinate extremes, lookahead short of the line distance and
// lookahead long enough to clamp at either end. The random part is mostly
// geometry at modest scale, so that the parameter lands between the ends,
// with full-range noise, degenerate segments and bad lookaheads mixed in.
// ----------------------------------------------------------------------------
module pure_pursuit_segment_lookahead_test;

    localparam int N_RANDOM    = 740;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [lkah_pkg::CW-1:0] coord_t;

    // One request as it is presented on the ports.
    typedef struct {
        coord_t c [3];
        coord_t s [3];
        coord_t e [3];
        coord_t ld;
    } request_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t cur_x, cur_y, cur_z;
    coord_t start_x, start_y, start_z;
    coord_t end_x, end_y, end_z;
    coord_t look_dist;
    logic   done;
    coord_t next_x, next_y, next_z;
    logic [lkah_pkg::TW-1:0] seg_param;
    logic   bad_lookahead;

    int mismatches;
    int outstanding;
    int compared;
    int cycles;
    int sent;
    int burst_left;

    pure_pursuit_segment_lookahead u_dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .look_dist(look_dist), .done(done),
        .next_x(next_x), .next_y(next_y), .next_z(next_z),
        .seg_param(seg_param), .bad_lookahead(bad_lookahead)
    );

    pure_pursuit_segment_lookahead_checker u_checker
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cur_x(cur_x), .cur_y(cur_y), .cur_z(cur_z),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .look_dist(look_dist), .done(done),
        .next_x(next_x), .next_y(next_y), .next_z(next_z),
        .seg_param(seg_param), .bad_lookahead(bad_lookahead),
        .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: a hung pipeline or a lost strobe ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Presents one request from a falling edge and holds it until the rising
    // edge at which busy is low, which is where the transfer happens. Busy
    // only moves at rising edges, so the value seen here is the one sampled.
    task automatic send_request(input request_t r);
        cur_x     = r.c[0];
        cur_y     = r.c[1];
        cur_z     = r.c[2];
        start_x   = r.s[0];
        start_y   = r.s[1];
        start_z   = r.s[2];
        end_x     = r.e[0];
        end_y     = r.e[1];
        end_z     = r.e[2];
        look_dist = r.ld;
        start     = 1'b1;
        forever
        begin
            if (!busy)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
            @(negedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    // Idle gap after a transfer: usually none or short, now and then long,
    // and during a burst none at all so back-to-back transfers get exercised.
    task automatic idle_gap();
        int n;
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        roll = $urandom_range(99);
        if (roll < 50)
            n = 0;
        else if (roll < 88)
            n = $urandom_range(1, 3);
        else if (roll < 96)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        if ($urandom_range(29) == 0)
            burst_left = $urandom_range(10, 40);
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic coord_t near_coord(input int span);
        return coord_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Random request. Most are believable geometry, scaled by a random
    // power of two, so every outcome of the projection gets visited.
    function automatic request_t random_request();
        request_t r;
        int       roll;
        int       span;
        roll = $urandom_range(99);
        span = 1 << $urandom_range(4, 26);
        for (int k = 0; k < 3; k++)
        begin
            r.s[k] = near_coord(span);
            r.e[k] = near_coord(span);
            r.c[k] = near_coord(span);
        end
        r.ld = coord_t'($urandom_range(1, 2 * span));
        if (roll < 15)
        begin
            // Full-range noise: every bit of every field flips.
            for (int k = 0; k < 3; k++)
            begin
                r.s[k] = $urandom;
                r.e[k] = $urandom;
                r.c[k] = $urandom;
            end
            r.ld = $urandom;
        end
        else if (roll < 22)
        begin
            r.e = r.s;
        end
        else if (roll < 30)
        begin
            r.ld = ($urandom_range(3) == 0) ? coord_t'(0) : coord_t'(-$urandom_range(1, span));
        end
        else if (roll < 40)
        begin
            // Lookahead short of the distance to the line: no advance.
            r.ld = coord_t'($urandom_range(1, 16));
        end
        return r;
    endfunction

    function automatic request_t make_request(input coord_t cx, cy, cz, sx, sy, sz,
                                              input coord_t ex, ey, ez, ld);
        request_t r;
        r.c  = '{cx, cy, cz};
        r.s  = '{sx, sy, sz};
        r.e  = '{ex, ey, ez};
        r.ld = ld;
        return r;
    endfunction

    initial
    begin
        request_t directed [$];
        coord_t   hi;
        coord_t   lo;
        coord_t   one;
        hi  = {1'b0, {(lkah_pkg::CW-1){1'b1}}};
        lo  = {1'b1, {(lkah_pkg::CW-1){1'b0}}};
        one = coord_t'(1) <<< lkah_pkg::FRAC_BITS;

        cycles     = 0;
        sent       = 0;
        burst_left = 0;
        start      = 1'b0;
        {cur_x, cur_y, cur_z, start_x, start_y, start_z} = '0;
        {end_x, end_y, end_z, look_dist} = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Non-positive lookahead: zero, minus one, most negative.
        directed.push_back(make_request(5, 6, 7, 0, 0, 0, one, 0, 0, 0));
        directed.push_back(make_request(hi, lo, hi, 0, 0, 0, one, one, 0, -1));
        directed.push_back(make_request(lo, hi, lo, 1, 2, 3, 4, 5, 6, lo));
        // Zero-length segment, ordinary and at the extremes.
        directed.push_back(make_request(one, one, one, 3, 3, 3, 3, 3, 3, one));
        directed.push_back(make_request(lo, lo, lo, hi, hi, hi, hi, hi, hi, hi));
        // Widest segments, with lookaheads from one LSB up to the largest.
        directed.push_back(make_request(0, 0, 0, lo, lo, lo, hi, hi, hi, hi));
        directed.push_back(make_request(hi, lo, 0, hi, hi, hi, lo, lo, lo, hi));
        directed.push_back(make_request(lo, lo, lo, lo, lo, lo, hi, hi, hi, 1));
        directed.push_back(make_request(hi, hi, hi, hi, lo, hi, lo, hi, lo, one));
        // Lookahead shorter than the line distance: plain projection.
        directed.push_back(make_request(one, 4*one, 0, 0, 0, 0, 2*one, 0, 0, one));
        directed.push_back(make_request(-one, 4*one, 0, 0, 0, 0, 2*one, 0, 0, one));
        directed.push_back(make_request(3*one, 4*one, 0, 0, 0, 0, 2*one, 0, 0, one));
        // Advance into the middle, past the end, and from behind the start.
        directed.push_back(make_request(0, one, 0, 0, 0, 0, 4*one, 0, 0, 2*one));
        directed.push_back(make_request(3*one, 0, 0, 0, 0, 0, 4*one, 0, 0, 2*one));
        directed.push_back(make_request(-5*one, 0, 0, 0, 0, 0, 4*one, 0, 0, 2*one));
        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 4*one, 4*one, 4*one, 1));
        // Unit-length segment and a lookahead of one LSB.
        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        directed.push_back(make_request(0, 0, 0, 0, 0, 0, 0, -1, 0, hi));

        foreach (directed[i])
        begin
            send_request(directed[i]);
            idle_gap();
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            send_request(random_request());
            idle_gap();
        end
        start = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (lkah_pkg::LATENCY + 10) @(negedge clk);

        $display("covered %0d requests (%0d directed), %0d results compared",
                 sent, directed.size(), compared);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lkah_pkg.sv
rtl/core/lkah_geom.sv
rtl/core/lkah_isqrt.sv
rtl/core/lkah_div.sv
rtl/core/lkah_interp.sv
rtl/core/pure_pursuit_segment_lookahead.sv
dv/pure_pursuit_segment_lookahead_checker.sv
dv/pure_pursuit_segment_lookahead_test.sv
